### rtl/sia_pkg.sv
// Package: opcodes, operation classes and the sideband carried down the pipeline.
`timescale 1ns / 1ps
package sia_pkg;

	localparam logic [5:0] OP_COPY     = 6'd0;
	localparam logic [5:0] OP_PIECE    = 6'd1;
	localparam logic [5:0] OP_SUBPIECE = 6'd2;
	localparam logic [5:0] OP_EQ       = 6'd3;
	localparam logic [5:0] OP_NE       = 6'd4;
	localparam logic [5:0] OP_SLESS    = 6'd5;
	localparam logic [5:0] OP_SLESSEQ  = 6'd6;
	localparam logic [5:0] OP_LESS     = 6'd7;
	localparam logic [5:0] OP_LESSEQ   = 6'd8;
	localparam logic [5:0] OP_ZEXT     = 6'd9;
	localparam logic [5:0] OP_SEXT     = 6'd10;
	localparam logic [5:0] OP_ADD      = 6'd11;
	localparam logic [5:0] OP_SUB      = 6'd12;
	localparam logic [5:0] OP_CARRY    = 6'd13;
	localparam logic [5:0] OP_SCARRY   = 6'd14;
	localparam logic [5:0] OP_SBORROW  = 6'd15;
	localparam logic [5:0] OP_NEG      = 6'd16;
	localparam logic [5:0] OP_NOT      = 6'd17;
	localparam logic [5:0] OP_XOR      = 6'd18;
	localparam logic [5:0] OP_AND      = 6'd19;
	localparam logic [5:0] OP_OR       = 6'd20;
	localparam logic [5:0] OP_SHL      = 6'd21;
	localparam logic [5:0] OP_SHR      = 6'd22;
	localparam logic [5:0] OP_SAR      = 6'd23;
	localparam logic [5:0] OP_MUL      = 6'd24;
	localparam logic [5:0] OP_DIV      = 6'd25;
	localparam logic [5:0] OP_SDIV     = 6'd26;
	localparam logic [5:0] OP_REM      = 6'd27;
	localparam logic [5:0] OP_SREM     = 6'd28;
	localparam logic [5:0] OP_BNOT     = 6'd29;
	localparam logic [5:0] OP_BXOR     = 6'd30;
	localparam logic [5:0] OP_BAND     = 6'd31;
	localparam logic [5:0] OP_BOR      = 6'd32;
	localparam logic [5:0] OP_POPCNT   = 6'd33;
	localparam logic [5:0] OP_LZCNT    = 6'd34;

	localparam int WORD_W = 64;
	localparam int DIV_STAGES = WORD_W;
	localparam logic [7:0] SIGN_BYTE = 8'h80;

	typedef enum logic [2:0] {
		K_SIMPLE = 3'd0,
		K_MUL    = 3'd1,
		K_UDIV   = 3'd2,
		K_UREM   = 3'd3,
		K_SDIV   = 3'd4,
		K_SREM   = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] simple;
		logic [63:0] pp0;
		logic [31:0] pp1;
		logic [31:0] pp2;
		logic [63:0] mo;
		logic        nn;
		logic        dn;
		logic        dz;
	} side_t;

endpackage

### rtl/sia_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface sia_req_if;
	logic        valid;
	logic        ready;
	logic [5:0]  command;
	logic [3:0]  size_in;
	logic [3:0]  size_out;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	modport source(output valid, command, size_in, size_out, operand_a, operand_b,
		input ready);
	modport sink(input valid, command, size_in, size_out, operand_a, operand_b,
		output ready);
endinterface

interface sia_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result;
	logic        status;
	modport source(output valid, result, status, input ready);
	modport sink(input valid, result, status, output ready);
endinterface

### rtl/sia_decode.sv
// First stage: size decode, simple ops, partial products, divider operands.
`timescale 1ns / 1ps
module sia_decode #(
	parameter int MAX_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  logic [5:0]         command,
	input  logic [3:0]         size_in,
	input  logic [3:0]         size_out,
	input  logic [63:0]        operand_a,
	input  logic [63:0]        operand_b,
	output logic               valid_s1,
	output sia_pkg::side_t     side_s1,
	output logic [63:0]        n_s1,
	output logic [63:0]        d_s1
);
	import sia_pkg::*;

	function automatic logic [3:0] clamp(input logic [3:0] s);
		if (s == 4'd0) return 4'd1;
		if (s > 4'(MAX_BYTES)) return 4'(MAX_BYTES);
		return s;
	endfunction

	function automatic logic [63:0] bmask(input logic [3:0] n);
		if (n >= 4'd8) return '1;
		return (64'd1 << {n[2:0], 3'b000}) - 64'd1;
	endfunction

	function automatic logic [6:0] clz64(input logic [63:0] v);
		logic [6:0] c;
		c = 7'd64;
		for (int i = 0; i < 64; i++) if (v[i]) c = 7'(63 - i);
		return c;
	endfunction

	logic [3:0]  si, so;
	logic [63:0] a, b, mi, mo, sbit, r, sum, dif, wa, wb;
	logic [5:0]  sp;
	logic        neg_a, x, y;
	kind_t       kind;

	assign a = operand_a;
	assign b = operand_b;
	assign si = clamp(size_in);
	assign so = clamp(size_out);
	assign mi = bmask(si);
	assign mo = bmask(so);
	assign sp = 6'({si, 3'b000} - 7'd1);
	assign sbit = {56'd0, SIGN_BYTE} << {si - 4'd1, 3'b000};
	assign sum = a + b;
	assign dif = a - b;
	assign neg_a = a[sp];
	assign wa = neg_a ? (a | ~mi) : (a & mi);
	assign wb = b[sp] ? (b | ~mi) : (b & mi);

	always_comb begin
		r = '0;
		x = |(a & sbit);
		y = |(b & sbit);
		kind = K_SIMPLE;
		case (command) inside
			OP_COPY, OP_ZEXT: r = a;
			OP_PIECE: r = (so > si) ? ((a << {so - si, 3'b000}) | b) : (a | b);
			OP_SUBPIECE: r = (b >= 64'd8) ? '0 : ((a >> {b[2:0], 3'b000}) & mo);
			OP_EQ: r = {63'd0, a == b};
			OP_NE: r = {63'd0, a != b};
			OP_SLESS: r = {63'd0, (x != y) ? x : (a < b)};
			OP_SLESSEQ: r = {63'd0, (x != y) ? x : (a <= b)};
			OP_LESS: r = {63'd0, a < b};
			OP_LESSEQ: r = {63'd0, a <= b};
			OP_SEXT: r = (so > si && neg_a) ? ((a & mi) | (mo & ~mi)) : (a & mi);
			OP_ADD: r = sum & mo;
			OP_SUB: r = dif & mo;
			OP_CARRY: r = {63'd0, a > (sum & mi)};
			OP_SCARRY: r = {63'd0, (sum[sp] ^ a[sp]) & ~(a[sp] ^ b[sp])};
			OP_SBORROW: r = {63'd0, (a[sp] ^ dif[sp]) & ~(dif[sp] ^ b[sp])};
			OP_NEG: r = ~(a - 64'd1) & mi;
			OP_NOT: r = ~a & mi;
			OP_XOR, OP_BXOR: r = a ^ b;
			OP_AND, OP_BAND: r = a & b;
			OP_OR, OP_BOR: r = a | b;
			OP_SHL: r = (b >= {57'd0, so, 3'b000}) ? '0 : ((a << b[5:0]) & mo);
			OP_SHR: r = (b >= {57'd0, so, 3'b000}) ? '0 : ((a & mo) >> b[5:0]);
			OP_SAR: begin
				if (b >= {57'd0, so, 3'b000}) r = neg_a ? mo : '0;
				else r = (a >> b[5:0]) | (neg_a ? ((mi >> b[5:0]) ^ mi) : '0);
			end
			OP_MUL: kind = K_MUL;
			OP_DIV: kind = K_UDIV;
			OP_REM: kind = K_UREM;
			OP_SDIV: kind = K_SDIV;
			OP_SREM: kind = K_SREM;
			OP_BNOT: r = a ^ 64'd1;
			OP_POPCNT: r = {57'd0, 7'($countones(a))};
			OP_LZCNT: r = {57'd0, clz64(a)} - {57'd0, 4'd8 - si, 3'b000};
			default: r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.kind <= kind;
			side_s1.simple <= r;
			side_s1.pp0 <= a[31:0] * b[31:0];
			side_s1.pp1 <= a[31:0] * b[63:32];
			side_s1.pp2 <= a[63:32] * b[31:0];
			side_s1.mo <= mo;
			if (kind == K_SDIV || kind == K_SREM) begin
				side_s1.nn <= wa[63];
				side_s1.dn <= wb[63];
				side_s1.dz <= (wb == '0);
				n_s1 <= wa[63] ? (64'd0 - wa) : wa;
				d_s1 <= wb[63] ? (64'd0 - wb) : wb;
			end else begin
				side_s1.nn <= 1'b0;
				side_s1.dn <= 1'b0;
				side_s1.dz <= (b == '0);
				n_s1 <= a;
				d_s1 <= b;
			end
		end
	end
endmodule

### rtl/sia_div.sv
// Radix-2 restoring divider, one quotient bit per stage, sideband carried along.
`timescale 1ns / 1ps
module sia_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid,
	input  sia_pkg::side_t side,
	input  logic [63:0]    n,
	input  logic [63:0]    d,
	output logic           valid_dv,
	output sia_pkg::side_t side_dv,
	output logic [63:0]    quo,
	output logic [63:0]    rem
);
	import sia_pkg::*;

	logic           vld_s [DIV_STAGES+1];
	side_t          side_s [DIV_STAGES+1];
	logic [63:0]    nq_s [DIV_STAGES+1];
	logic [63:0]    rem_s [DIV_STAGES+1];
	logic [63:0]    dvs_s [DIV_STAGES+1];

	assign vld_s[0] = valid;
	assign side_s[0] = side;
	assign nq_s[0] = n;
	assign rem_s[0] = '0;
	assign dvs_s[0] = d;

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		logic [64:0] t;
		logic        ge;
		logic [64:0] t_sub;
		assign t = {rem_s[k-1], nq_s[k-1][63]};
		assign ge = t >= {1'b0, dvs_s[k-1]};
		assign t_sub = t - {1'b0, dvs_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				dvs_s[k] <= dvs_s[k-1];
				nq_s[k] <= {nq_s[k-1][62:0], ge};
				rem_s[k] <= ge ? t_sub[63:0] : t[63:0];
			end
		end
	end

	assign valid_dv = vld_s[DIV_STAGES];
	assign side_dv = side_s[DIV_STAGES];
	assign quo = nq_s[DIV_STAGES];
	assign rem = rem_s[DIV_STAGES];
endmodule

### rtl/sia_finish.sv
// Last stage: product sum, signed fixup of quotient and remainder, result select.
`timescale 1ns / 1ps
module sia_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid,
	input  sia_pkg::side_t side,
	input  logic [63:0]    quo,
	input  logic [63:0]    rem,
	output logic           valid_q,
	output logic [63:0]    result_q,
	output logic           status_q
);
	import sia_pkg::*;

	logic [63:0] prod, r;
	logic        st;

	assign prod = side.pp0 + {side.pp1 + side.pp2, 32'd0};

	always_comb begin
		r = side.simple;
		st = 1'b0;
		case (side.kind)
			K_MUL: r = prod & side.mo;
			K_UDIV: r = quo;
			K_UREM: r = rem;
			K_SDIV: r = ((side.nn != side.dn) ? (64'd0 - quo) : quo) & side.mo;
			K_SREM: r = (side.nn ? (64'd0 - rem) : rem) & side.mo;
			default: r = side.simple;
		endcase
		if (side.kind inside {K_UDIV, K_UREM, K_SDIV, K_SREM} && side.dz) begin
			r = '0;
			st = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= r;
			status_q <= st;
		end
	end
endmodule

### rtl/sized_integer_pcode_alu.sv
// Top level: sized integer ALU, decode stage, divider stages and result stage.
//  channel | dir | payload
//  req     | in  | command, size_in, size_out, operand_a, operand_b
//  rsp     | out | result, status
// Every op passes one decode stage, 64 divider stages and one result stage.
// One request is accepted per cycle while the response is not stalled; the 64-stage divider sets the latency.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
module sized_integer_pcode_alu #(
	parameter int MAX_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	sia_req_if.sink   req,
	sia_rsp_if.source rsp
);
	import sia_pkg::*;

	logic        en, v_s1, v_dv;
	side_t       side_s1, side_dv;
	logic [63:0] n_s1, d_s1, quo, rem;

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	sia_decode #(.MAX_BYTES(MAX_BYTES)) u_dec (
		.clk, .arst_n, .en,
		.valid(req.valid), .command(req.command), .size_in(req.size_in),
		.size_out(req.size_out), .operand_a(req.operand_a), .operand_b(req.operand_b),
		.valid_s1(v_s1), .side_s1(side_s1), .n_s1(n_s1), .d_s1(d_s1)
	);

	sia_div u_div (
		.clk, .arst_n, .en,
		.valid(v_s1), .side(side_s1), .n(n_s1), .d(d_s1),
		.valid_dv(v_dv), .side_dv(side_dv), .quo(quo), .rem(rem)
	);

	sia_finish u_fin (
		.clk, .arst_n, .en,
		.valid(v_dv), .side(side_dv), .quo(quo), .rem(rem),
		.valid_q(rsp.valid), .result_q(rsp.result), .status_q(rsp.status)
	);
endmodule

### rtl/sia_checker.sv
// Port checker for the sized integer ALU and its bind.
`timescale 1ns / 1ps
module sia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_result,
	input logic        rsp_status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
		else $error("response changed while stalled");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_result == 64'd0)
		else $error("error response with nonzero result");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while pipeline frozen");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty output");
endmodule

bind sized_integer_pcode_alu sia_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_ready(req.ready), .rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready), .rsp_result(rsp.result), .rsp_status(rsp.status)
);
